/* design/frlc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frlc_pkg
// Shared types, sizes and helpers of the flash ring log cursor: ring
// geometry, opcode and register index codes, and the channel payloads.
// ----------------------------------------------------------------------------
package frlc_pkg;

    // Ring geometry
    localparam int PAGE_BYTES     = 2048;
    localparam int SLOT_BYTES     = 104;
    localparam int SLOTS_PER_PAGE = 19;
    localparam int PAGE_COUNT     = 40;
    localparam int BANK_PAGES     = 256;
    localparam int SLOT_TOTAL     = PAGE_COUNT * SLOTS_PER_PAGE;

    // Field widths
    localparam int OPC_W  = 3;
    localparam int IDX_W  = 10;
    localparam int SEQ_W  = 16;
    localparam int TIME_W = 32;
    localparam int ADDR_W = 32;
    localparam int FPG_W  = 9;
    localparam int EPG_W  = 8;
    localparam int CFG_W  = 32;
    localparam int CFGI_W = 2;

    // Internal widths
    localparam int PAGE_W = ($clog2(PAGE_COUNT) > 0) ? $clog2(PAGE_COUNT) : 1;
    localparam int SLOT_W = ($clog2(SLOTS_PER_PAGE) > 0) ? $clog2(SLOTS_PER_PAGE) : 1;
    localparam int ABS_W  = 11;

    // Reciprocal for the slot-to-page split: exact for any 10-bit index,
    // since the rounding error times 1023 stays below 2**RECIP_SHIFT.
    localparam int RECIP_SHIFT = 20;
    localparam int RECIP       = (2**RECIP_SHIFT + SLOTS_PER_PAGE - 1) / SLOTS_PER_PAGE;
    localparam int RECIP_W     = RECIP_SHIFT + 1;

    // Reset values of the configuration registers
    localparam logic [TIME_W-1:0] PERIOD_RESET = TIME_W'(1000);
    localparam logic [TIME_W-1:0] STOP_RESET   = '1;

    typedef enum logic [OPC_W-1:0] {
        OP_BEGIN_SCAN  = 3'd0,
        OP_SCAN_SLOT   = 3'd1,
        OP_FINISH_SCAN = 3'd2,
        OP_STORE_NOW   = 3'd3,
        OP_TIME_TICK   = 3'd4
    } t_opcode;

    typedef enum logic [CFGI_W-1:0] {
        CFG_BASE_ADDR  = 2'd0,
        CFG_FIRST_PAGE = 2'd1,
        CFG_PERIOD     = 2'd2,
        CFG_STOP_TIME  = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [OPC_W-1:0]  opcode;
        logic [IDX_W-1:0]  slot_index;
        logic              slot_valid;
        logic [SEQ_W-1:0]  slot_seq;
        logic [TIME_W-1:0] now_ms;
    } t_in_item;

    typedef struct packed {
        logic              erase_now;
        logic              erase_bank;
        logic [EPG_W-1:0]  erase_page;
        logic              program_now;
        logic [ADDR_W-1:0] program_addr;
        logic [SEQ_W-1:0]  record_seq;
        logic [IDX_W-1:0]  next_write_index;
        logic              newest_found;
        logic [IDX_W-1:0]  newest_index;
        logic [SEQ_W-1:0]  newest_stamp;
    } t_out_item;

    // Wrap-aware compare: a is newer than b within half the sequence space
    function automatic logic seq_newer(input logic [SEQ_W-1:0] a,
                                       input logic [SEQ_W-1:0] b);
        logic [SEQ_W-1:0] d;
        d = a - b;
        return (d != '0) && !d[SEQ_W-1];
    endfunction

endpackage

/* design/frlc_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frlc_in_if
// Event channel into the cursor block: valid/ready plus one event.
// ----------------------------------------------------------------------------
interface frlc_in_if;
    logic                          valid;
    logic                          ready;
    logic [frlc_pkg::OPC_W-1:0]    opcode;
    logic [frlc_pkg::IDX_W-1:0]    slot_index;
    logic                          slot_valid;
    logic [frlc_pkg::SEQ_W-1:0]    slot_seq;
    logic [frlc_pkg::TIME_W-1:0]   now_ms;

    modport source (output valid, opcode, slot_index, slot_valid, slot_seq, now_ms,
                    input ready);
    modport sink   (input valid, opcode, slot_index, slot_valid, slot_seq, now_ms,
                    output ready);
endinterface

/* design/frlc_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frlc_out_if
// Result channel of the cursor block: valid/ready plus one result.
// ----------------------------------------------------------------------------
interface frlc_out_if;
    logic                          valid;
    logic                          ready;
    logic                          erase_now;
    logic                          erase_bank;
    logic [frlc_pkg::EPG_W-1:0]    erase_page;
    logic                          program_now;
    logic [frlc_pkg::ADDR_W-1:0]   program_addr;
    logic [frlc_pkg::SEQ_W-1:0]    record_seq;
    logic [frlc_pkg::IDX_W-1:0]    next_write_index;
    logic                          newest_found;
    logic [frlc_pkg::IDX_W-1:0]    newest_index;
    logic [frlc_pkg::SEQ_W-1:0]    newest_stamp;

    modport source (output valid, erase_now, erase_bank, erase_page, program_now,
                    program_addr, record_seq, next_write_index, newest_found,
                    newest_index, newest_stamp,
                    input ready);
    modport sink   (input valid, erase_now, erase_bank, erase_page, program_now,
                    program_addr, record_seq, next_write_index, newest_found,
                    newest_index, newest_stamp,
                    output ready);
endinterface

/* design/flash_ring_log_cursor_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flash_ring_log_cursor_top
// Write cursor of a flash ring of fixed-size records: recovery scan,
// store addressing with page erase requests, and periodic store timing.
// ----------------------------------------------------------------------------
// Usage:
//   i_in   event channel (valid/ready): begin scan, scan slot, finish scan,
//          store now, time tick, each with its slot and time fields.
//   o_out  result channel (valid/ready): one result per event, carrying the
//          erase and program requests and the cursor and scan state.
//   i_cfg_* write port for the four configuration registers; write only
//          while no event is in flight.
//   From input transaction to result, the event lands in the input
//   register, is decoded and applied to the cursor state in
//   combinational logic, and the result is held in the output register.
//   Throughput is one transaction per cycle while the receiver takes
//   results; the critical path is the reciprocal multiply that splits
//   the cursor into page and slot, followed by the address add.
//   When the receiver stalls, the result register holds and one more event
//   waits in the input register; i_in.ready drops only when both are full.
//   Synchronous reset clears the cursor, sequence, timer and scan state to
//   zero, loads the register defaults and empties both stages.
// ----------------------------------------------------------------------------
module flash_ring_log_cursor_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    frlc_in_if.sink                      i_in,
    frlc_out_if.source                   o_out,
    input  logic                         i_cfg_we,
    input  logic [frlc_pkg::CFGI_W-1:0]  i_cfg_idx,
    input  logic [frlc_pkg::CFG_W-1:0]   i_cfg_data
);

    localparam int IDX_W  = frlc_pkg::IDX_W;
    localparam int SEQ_W  = frlc_pkg::SEQ_W;
    localparam int TIME_W = frlc_pkg::TIME_W;
    localparam int ADDR_W = frlc_pkg::ADDR_W;
    localparam int PAGE_W = frlc_pkg::PAGE_W;
    localparam int SLOT_W = frlc_pkg::SLOT_W;
    localparam int ABS_W  = frlc_pkg::ABS_W;
    localparam int PROD_W = IDX_W + frlc_pkg::RECIP_W;

    // Configuration registers
    logic [ADDR_W-1:0]          r_base_addr;
    logic [frlc_pkg::FPG_W-1:0] r_first_page;
    logic [TIME_W-1:0]          r_period;
    logic [TIME_W-1:0]          r_stop_time;

    // Cursor and scan state
    logic [IDX_W-1:0]  r_write_cursor, n_write_cursor;
    logic [SEQ_W-1:0]  r_next_seq,     n_next_seq;
    logic [TIME_W-1:0] r_last_store,   n_last_store;
    logic [IDX_W-1:0]  r_best_slot,    n_best_slot;
    logic [SEQ_W-1:0]  r_best_stamp,   n_best_stamp;
    logic              r_best_seen,    n_best_seen;

    // Pipeline stages
    logic                 r_in_vld;
    frlc_pkg::t_in_item   r_in;
    logic                 r_out_vld;
    frlc_pkg::t_out_item  r_out, n_out;
    logic                 w_adv;

    // Store address datapath
    logic [PROD_W-1:0] w_prod;
    logic [PAGE_W-1:0] w_page;
    logic [IDX_W-1:0]  w_slot_full;
    logic [SLOT_W-1:0] w_slot;
    logic [ABS_W-1:0]  w_abs_page;
    logic              w_bank;
    logic [ABS_W-1:0]  w_bank_page;
    logic [ADDR_W-1:0] w_addr;
    logic [IDX_W-1:0]  w_cursor_inc;
    logic [IDX_W-1:0]  w_best_inc;
    logic              w_do_store;
    logic              w_tick_due;

    // Handshake: advance when the result register is free or being drained
    assign w_adv      = r_in_vld && (!r_out_vld || o_out.ready);
    assign i_in.ready = !r_in_vld || !r_out_vld || o_out.ready;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_addr  <= '0;
            r_first_page <= '0;
            r_period     <= frlc_pkg::PERIOD_RESET;
            r_stop_time  <= frlc_pkg::STOP_RESET;
        end else if (i_cfg_we) begin
            unique case (frlc_pkg::t_cfg_idx'(i_cfg_idx))
                frlc_pkg::CFG_BASE_ADDR:  r_base_addr  <= i_cfg_data;
                frlc_pkg::CFG_FIRST_PAGE: r_first_page <= i_cfg_data[frlc_pkg::FPG_W-1:0];
                frlc_pkg::CFG_PERIOD:     r_period     <= i_cfg_data;
                frlc_pkg::CFG_STOP_TIME:  r_stop_time  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Split the cursor into page and slot within the page
    assign w_prod      = PROD_W'(r_write_cursor) * PROD_W'(frlc_pkg::RECIP);
    assign w_page      = w_prod[frlc_pkg::RECIP_SHIFT +: PAGE_W];
    assign w_slot_full = r_write_cursor
                         - IDX_W'(IDX_W'(w_page) * IDX_W'(frlc_pkg::SLOTS_PER_PAGE));
    assign w_slot      = w_slot_full[SLOT_W-1:0];

    // Erase target: absolute page, folded into the second bank when past it
    assign w_abs_page  = ABS_W'(r_first_page) + ABS_W'(w_page);
    assign w_bank      = (w_abs_page >= ABS_W'(frlc_pkg::BANK_PAGES));
    assign w_bank_page = w_bank ? (w_abs_page - ABS_W'(frlc_pkg::BANK_PAGES)) : w_abs_page;

    // Slot byte address, wrapping modulo 2**32
    assign w_addr = r_base_addr
                    + ADDR_W'(w_page) * ADDR_W'(frlc_pkg::PAGE_BYTES)
                    + ADDR_W'(w_slot) * ADDR_W'(frlc_pkg::SLOT_BYTES);

    // Ring increments of the cursor and of the newest slot
    assign w_cursor_inc = (r_write_cursor == IDX_W'(frlc_pkg::SLOT_TOTAL - 1))
                          ? '0 : r_write_cursor + IDX_W'(1);
    assign w_best_inc   = (r_best_slot == IDX_W'(frlc_pkg::SLOT_TOTAL - 1))
                          ? '0 : r_best_slot + IDX_W'(1);

    // Periodic store is due once the period has run and before stop time
    assign w_tick_due = (r_in.now_ms < r_stop_time)
                        && ((r_in.now_ms - r_last_store) >= r_period);

    // Decode the event and work out the next state and the result
    always_comb begin
        n_write_cursor = r_write_cursor;
        n_next_seq     = r_next_seq;
        n_last_store   = r_last_store;
        n_best_slot    = r_best_slot;
        n_best_stamp   = r_best_stamp;
        n_best_seen    = r_best_seen;
        w_do_store     = 1'b0;

        unique case (frlc_pkg::t_opcode'(r_in.opcode))
            frlc_pkg::OP_BEGIN_SCAN: begin
                n_best_seen  = 1'b0;
                n_best_slot  = '0;
                n_best_stamp = '0;
            end
            frlc_pkg::OP_SCAN_SLOT: begin
                if ((r_in.slot_index < IDX_W'(frlc_pkg::SLOT_TOTAL)) && r_in.slot_valid
                    && (!r_best_seen
                        || frlc_pkg::seq_newer(r_in.slot_seq, r_best_stamp))) begin
                    n_best_seen  = 1'b1;
                    n_best_slot  = r_in.slot_index;
                    n_best_stamp = r_in.slot_seq;
                end
            end
            frlc_pkg::OP_FINISH_SCAN: begin
                n_next_seq     = r_best_seen ? r_best_stamp + SEQ_W'(1) : '0;
                n_write_cursor = r_best_seen ? w_best_inc : '0;
                n_last_store   = r_in.now_ms;
            end
            frlc_pkg::OP_STORE_NOW: begin
                w_do_store = 1'b1;
            end
            frlc_pkg::OP_TIME_TICK: begin
                w_do_store = w_tick_due;
            end
            default: ;
        endcase

        // Advance the cursor on a store
        if (w_do_store) begin
            n_next_seq     = r_next_seq + SEQ_W'(1);
            n_write_cursor = w_cursor_inc;
            n_last_store   = r_in.now_ms;
        end

        n_out.erase_now        = w_do_store && (w_slot == '0);
        n_out.erase_bank       = n_out.erase_now && w_bank;
        n_out.erase_page       = n_out.erase_now ? w_bank_page[frlc_pkg::EPG_W-1:0] : '0;
        n_out.program_now      = w_do_store;
        n_out.program_addr     = w_do_store ? w_addr : '0;
        n_out.record_seq       = w_do_store ? r_next_seq : '0;
        n_out.next_write_index = n_write_cursor;
        n_out.newest_found     = n_best_seen;
        n_out.newest_index     = n_best_slot;
        n_out.newest_stamp     = n_best_stamp;
    end

    // Input register: capture an event on every input transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_vld <= 1'b1;
        end else if (w_adv) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in.opcode     <= i_in.opcode;
            r_in.slot_index <= i_in.slot_index;
            r_in.slot_valid <= i_in.slot_valid;
            r_in.slot_seq   <= i_in.slot_seq;
            r_in.now_ms     <= i_in.now_ms;
        end
    end

    // Commit state and result together when the event advances
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld      <= 1'b0;
            r_write_cursor <= '0;
            r_next_seq     <= '0;
            r_last_store   <= '0;
            r_best_slot    <= '0;
            r_best_stamp   <= '0;
            r_best_seen    <= 1'b0;
        end else if (w_adv) begin
            r_out_vld      <= 1'b1;
            r_write_cursor <= n_write_cursor;
            r_next_seq     <= n_next_seq;
            r_last_store   <= n_last_store;
            r_best_slot    <= n_best_slot;
            r_best_stamp   <= n_best_stamp;
            r_best_seen    <= n_best_seen;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    // Drive the result channel
    assign o_out.valid            = r_out_vld;
    assign o_out.erase_now        = r_out.erase_now;
    assign o_out.erase_bank       = r_out.erase_bank;
    assign o_out.erase_page       = r_out.erase_page;
    assign o_out.program_now      = r_out.program_now;
    assign o_out.program_addr     = r_out.program_addr;
    assign o_out.record_seq       = r_out.record_seq;
    assign o_out.next_write_index = r_out.next_write_index;
    assign o_out.newest_found     = r_out.newest_found;
    assign o_out.newest_index     = r_out.newest_index;
    assign o_out.newest_stamp     = r_out.newest_stamp;

    // Cursor never leaves the ring
    a_cursor_in_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_write_cursor < IDX_W'(frlc_pkg::SLOT_TOTAL))
        else $error("write cursor outside the ring");

    // A kept record always names a slot of the ring
    a_best_in_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_best_seen |-> (r_best_slot < IDX_W'(frlc_pkg::SLOT_TOTAL)))
        else $error("newest slot outside the ring");

    // A forced store always yields a program request
    a_store_programs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && (r_in.opcode == frlc_pkg::OP_STORE_NOW))
        |=> (r_out_vld && r_out.program_now))
        else $error("store event without program request");

    // Erase is only requested together with a program request
    a_erase_with_program: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.erase_now) |-> r_out.program_now)
        else $error("erase request without program request");

endmodule
